### rtl/core/length_prefixed_packet_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; each assertion file includes this header.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lppd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
// No dependencies.
package lppd_pkg;

	localparam int HEADER_BYTES = 6;
	localparam int LEN_BYTES    = 4;
	localparam int TYPE_LO_POS  = LEN_BYTES;
	localparam int TYPE_HI_POS  = LEN_BYTES + 1;
	localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK = 1'd1;

	localparam logic [15:0] MAX_LEN_RST   = 16'd4096;
	localparam logic [63:0] TYPE_MASK_RST = 64'd0;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [HDR_CNT_W-1:0] hdr_cnt_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Classified result on its way from front to back.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] pkt_type;
		logic [7:0]  data;
		logic [15:0] total_len;
		logic        last;
	} evt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/core/lppd_front.sv
// Front end: header parse, length check, type lookup and payload counting.
// Depends on lppd_pkg and the shared assertion macros.
`include "length_prefixed_packet_deframer_macros.svh"

module lppd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [7:0]                         rx_byte,
	input  logic                               cfg_we,
	input  logic [lppd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lppd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  lppd_pkg::q_stat_t                  q_stat,
	output logic                               q_push,
	output lppd_pkg::evt_t                     q_evt
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_DROP
	} phase_t;

	phase_t             phase_q, phase_nx;
	lppd_pkg::hdr_cnt_t hdr_cnt_q, hdr_cnt_nx;
	logic [31:0]        len_q, len_nx, len_hd;
	logic [15:0]        type_q, type_nx, type_hd;
	logic [15:0]        remain_q, remain_nx;
	logic               known_q, known_nx, known_hd;
	logic [15:0]        max_len_q;
	logic [63:0]        type_mask_q;
	logic               fire;
	logic               hdr_done;
	logic               len_bad;
	logic [15:0]        plen_hd;
	logic               fin;

	assign in_ready = !q_stat.full;
	assign fire     = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= lppd_pkg::MAX_LEN_RST;
			type_mask_q <= lppd_pkg::TYPE_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lppd_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_wdata[15:0];
				lppd_pkg::CFG_TYPE_MASK: type_mask_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Header byte capture and completion checks
	always_comb begin
		len_hd  = len_q;
		type_hd = type_q;
		for (int i = 0; i < lppd_pkg::LEN_BYTES; i++) begin
			if (hdr_cnt_q == lppd_pkg::hdr_cnt_t'(i))
				len_hd[8*i +: 8] = rx_byte;
		end
		if (hdr_cnt_q == lppd_pkg::hdr_cnt_t'(lppd_pkg::TYPE_LO_POS))
			type_hd[7:0] = rx_byte;
		if (hdr_cnt_q == lppd_pkg::hdr_cnt_t'(lppd_pkg::TYPE_HI_POS))
			type_hd[15:8] = rx_byte;
		hdr_done = (hdr_cnt_q == lppd_pkg::hdr_cnt_t'(lppd_pkg::HEADER_BYTES - 1));
		len_bad  = (len_hd < 32'(lppd_pkg::HEADER_BYTES)) || (len_hd > {16'd0, max_len_q});
		plen_hd  = len_hd[15:0] - 16'(lppd_pkg::HEADER_BYTES);
		known_hd = (type_hd[15:6] == 10'd0) && type_mask_q[type_hd[5:0]];
	end

	assign fin = (remain_q <= 16'd1);

	always_comb begin
		phase_nx   = phase_q;
		hdr_cnt_nx = hdr_cnt_q;
		len_nx     = len_q;
		type_nx    = type_q;
		remain_nx  = remain_q;
		known_nx   = known_q;
		q_push     = 1'b0;
		q_evt      = '{kind: lppd_pkg::KIND_DATA, pkt_type: type_q, data: rx_byte,
			total_len: len_q[15:0], last: fin};
		if (fire) begin
			if (req_type) begin
				phase_nx   = PH_HEADER;
				hdr_cnt_nx = '0;
				len_nx     = '0;
				type_nx    = '0;
				remain_nx  = '0;
				known_nx   = 1'b0;
			end else begin
				case (phase_q)
					PH_DROP: ;
					PH_PAYLOAD: begin
						q_push = known_q;
						if (fin) begin
							phase_nx   = PH_HEADER;
							hdr_cnt_nx = '0;
							len_nx     = '0;
							type_nx    = '0;
							remain_nx  = '0;
							known_nx   = 1'b0;
						end else begin
							remain_nx = remain_q - 16'd1;
						end
					end
					default: begin
						// header phase; an unused code behaves the same
						len_nx  = len_hd;
						type_nx = type_hd;
						if (!hdr_done) begin
							hdr_cnt_nx = hdr_cnt_q + 1'b1;
						end else begin
							hdr_cnt_nx = '0;
							if (len_bad) begin
								q_push   = 1'b1;
								q_evt    = '{kind: lppd_pkg::KIND_ERROR, pkt_type: type_hd,
									data: 8'd0, total_len: 16'd0, last: 1'b1};
								phase_nx = PH_DROP;
							end else if (plen_hd == 16'd0) begin
								q_push     = known_hd;
								q_evt      = '{kind: lppd_pkg::KIND_EMPTY, pkt_type: type_hd,
									data: 8'd0, total_len: 16'd0, last: 1'b1};
								phase_nx   = PH_HEADER;
								len_nx     = '0;
								type_nx    = '0;
								remain_nx  = '0;
								known_nx   = 1'b0;
							end else begin
								remain_nx = plen_hd;
								known_nx  = known_hd;
								phase_nx  = PH_PAYLOAD;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			type_q    <= '0;
			remain_q  <= '0;
			known_q   <= 1'b0;
		end else begin
			phase_q   <= phase_nx;
			hdr_cnt_q <= hdr_cnt_nx;
			len_q     <= len_nx;
			type_q    <= type_nx;
			remain_q  <= remain_nx;
			known_q   <= known_nx;
		end
	end

	`LPPD_ASSERT_IMP(a_payload_left, clk, arst_n, phase_q == PH_PAYLOAD, remain_q != 16'd0, "payload phase with nothing left")
	`LPPD_ASSERT_IMP(a_push_room, clk, arst_n, q_push, !q_stat.full, "push into full queue")

endmodule

### rtl/core/lppd_fifo.sv
// Short register queue between the deframer front and back ends.
// Depends on lppd_pkg and the shared assertion macros.
`include "length_prefixed_packet_deframer_macros.svh"

module lppd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lppd_pkg::evt_t    push_evt,
	input  logic              pop,
	output lppd_pkg::evt_t    pop_evt,
	output lppd_pkg::q_stat_t stat
);

	lppd_pkg::evt_t                     ent_q [lppd_pkg::FIFO_DEPTH];
	logic [lppd_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [lppd_pkg::FIFO_CNT_W-1:0]    cnt_q;

	function automatic logic [lppd_pkg::FIFO_PTR_W-1:0] ptr_inc(
		input logic [lppd_pkg::FIFO_PTR_W-1:0] p);
		return (p == lppd_pkg::FIFO_PTR_W'(lppd_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full  = (cnt_q == lppd_pkg::FIFO_CNT_W'(lppd_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_evt    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`LPPD_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, !stat.empty, "pop from empty queue")
	`LPPD_ASSERT_NXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

### rtl/core/lppd_back.sv
// Back end: drains the queue into the output register and forms result fields.
// Depends on lppd_pkg.
module lppd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lppd_pkg::q_stat_t q_stat,
	input  lppd_pkg::evt_t    q_evt,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [15:0]       pkt_type,
	output logic [7:0]        data_byte,
	output logic [15:0]       body_len,
	output logic              last
);

	logic               out_valid_q;
	lppd_pkg::kind_t    kind_q;
	logic [15:0]        pkt_type_q;
	logic [7:0]         data_q;
	logic [15:0]        plen_q;
	logic               last_q;
	logic               is_data;

	assign q_pop   = !q_stat.empty && (!out_valid_q || out_ready);
	assign is_data = (q_evt.kind == lppd_pkg::KIND_DATA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || out_ready)
			out_valid_q <= !q_stat.empty;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q     <= q_evt.kind;
			pkt_type_q <= q_evt.pkt_type;
			data_q     <= is_data ? q_evt.data : 8'd0;
			plen_q     <= is_data ? q_evt.total_len - 16'(lppd_pkg::HEADER_BYTES) : 16'd0;
			last_q     <= q_evt.last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign pkt_type  = pkt_type_q;
	assign data_byte = data_q;
	assign body_len  = plen_q;
	assign last      = last_q;

endmodule

### rtl/core/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer: front, queue and back.
// Depends on lppd_pkg, lppd_front, lppd_fifo and lppd_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | req_type, rx_byte
//   out      | out_valid / out_ready| kind, pkt_type, data_byte, body_len, last
//   cfg      | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready is high; a result is written to the queue
// when its item is accepted and then moves on to the output register.
// in_ready is the queue's not-full flag only, so it never depends on out_ready
// in the same cycle; a stalled output fills the two-entry queue, then in_ready drops.
// Reset (arst_n low) returns the parser to the header phase, empties the queue
// and loads the register defaults (max length 4096, no known types).
module length_prefixed_packet_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [7:0]                        rx_byte,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        kind,
	output logic [15:0]                       pkt_type,
	output logic [7:0]                        data_byte,
	output logic [15:0]                       body_len,
	output logic                              last,
	// register writes
	input  logic                              cfg_we,
	input  logic [lppd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lppd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	lppd_pkg::q_stat_t q_stat;
	lppd_pkg::evt_t    push_evt;
	lppd_pkg::evt_t    pop_evt;
	logic              q_push;
	logic              q_pop;

	// Front: parses the header, checks the length against the limit, looks the
	// type up in the mask and counts payload bytes; emits at most one event per item.
	lppd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_evt     (push_evt)
	);

	// Queue decouples the parser from output back-pressure.
	lppd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_evt (push_evt),
		.pop      (q_pop),
		.pop_evt  (pop_evt),
		.stat     (q_stat)
	);

	// Back: forms payload length and data fields and holds the result item.
	lppd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_evt     (pop_evt),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.pkt_type  (pkt_type),
		.data_byte (data_byte),
		.body_len  (body_len),
		.last      (last)
	);

endmodule
